// ----- sv/hcbd_pkg.sv -----
// ----------------------------------------------------------------------------
// hcbd_pkg: shared types and constants for the chunked body decoder
// Holds the parse phase type, the status codes and the byte class helpers.
// ----------------------------------------------------------------------------
package hcbd_pkg;

    // Parse phase of the decoder.
    typedef enum logic [2:0] {
        PH_LEAD   = 3'd0,
        PH_ZERO   = 3'd1,
        PH_PREFIX = 3'd2,
        PH_DIGITS = 3'd3,
        PH_TAIL   = 3'd4,
        PH_DATA   = 3'd5,
        PH_SEP    = 3'd6,
        PH_HALT   = 3'd7
    } phase_t;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_PAYLOAD   = 3'd0,
        ST_DONE      = 3'd1,
        ST_NO_CRLF   = 3'd2,
        ST_BAD_SIZE  = 3'd3,
        ST_TRUNCATED = 3'd4
    } status_t;

    // Digit tracking on the size line.
    typedef enum logic [1:0] {
        DC_NONE     = 2'd0,
        DC_SOME     = 2'd1,
        DC_OVERFLOW = 2'd2
    } digit_cnt_t;

    localparam int unsigned HEX_DIGIT_BITS = 4;
    localparam int unsigned SEP_LEN        = 2;

    localparam logic [7:0] CHR_CR    = 8'h0D;
    localparam logic [7:0] CHR_LF    = 8'h0A;
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_X_LC  = 8'h78;
    localparam logic [7:0] CHR_X_UC  = 8'h58;
    localparam logic [7:0] CHR_SPACE = 8'h20;

    // Hex digit decode: bit 4 flags a valid digit, bits 3:0 carry its value.
    function automatic logic [4:0] hex_decode(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, 4'(b - 8'h30)};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            r = {1'b1, 4'(b - 8'h57)};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            r = {1'b1, 4'(b - 8'h37)};
        end
        return r;
    endfunction

    // Space, TAB, LF, VT, FF and CR count as blanks.
    function automatic logic is_blank(input logic [7:0] b);
        return (b == CHR_SPACE) || (b >= 8'h09 && b <= 8'h0D);
    endfunction

endpackage

// ----- sv/http_chunked_body_decoder.sv -----
// ----------------------------------------------------------------------------
// http_chunked_body_decoder: HTTP chunked transfer body decoder
// Parses chunk size lines and passes out chunk payload bytes, one body byte
// per cycle unless the output stalls, with a single status result for each body.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ side takes one body byte per request in s_tdata; a request with
//   s_tlast high marks the end of the body and carries no byte. The m_ side
//   gives payload bytes (status 0 in m_tuser) and one final status per body:
//   1 done, 2 size line without CR LF, 3 bad size, 4 truncated chunk.
//   Each accepted byte is decoded in the cycle it is taken and its result, if
//   any, appears on the m_ side in the next cycle from the output register.
//   Throughput is one byte per clock; the only limit is the single output
//   register, so s_tready drops only while a result waits and m_tready is low.
//   When the receiver stalls, the held result stays stable and no new byte
//   is taken. Reset puts the parser at the start of a size line with no
//   result pending. An end-of-body request always returns the parser to
//   the start of a size line, ready for the next body.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder
    import hcbd_pkg::*;
#(
    parameter int unsigned SIZE_BITS = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,   // end_of_body
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] payload_byte
    output logic [2:0] m_tuser    // [2:0] status
);

    // Parser state.
    phase_t                 phase_reg, phase_next;
    logic [SIZE_BITS-1:0]   acc_reg, acc_next;
    digit_cnt_t             digits_reg, digits_next;
    logic                   saw_cr_reg, saw_cr_next;
    logic [SIZE_BITS-1:0]   remain_reg, remain_next;
    logic                   line_started_reg, line_started_next;
    logic                   reported_reg, reported_next;

    // Output register.
    logic                   out_valid_reg, out_valid_next;
    logic [7:0]             out_byte_reg;
    status_t                out_status_reg;

    // Per-request result.
    logic                   res_valid;
    logic [7:0]             res_byte;
    status_t                res_status;

    logic                   accept;
    logic [4:0]             hex;
    logic                   is_digit;
    logic [SIZE_BITS-1:0]   remain_dec;
    logic                   line_end;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign hex        = hex_decode(s_tdata);
    assign is_digit   = hex[4];
    assign remain_dec = remain_reg - SIZE_BITS'(1);
    assign line_end   = (s_tdata == CHR_LF) && saw_cr_reg;

    // Next-state logic of the parser.
    always_comb
    begin
        phase_next        = phase_reg;
        acc_next          = acc_reg;
        digits_next       = digits_reg;
        saw_cr_next       = saw_cr_reg;
        remain_next       = remain_reg;
        line_started_next = line_started_reg;
        reported_next     = reported_reg;

        if (accept) begin
            if (s_tlast) begin
                phase_next        = PH_LEAD;
                acc_next          = '0;
                digits_next       = DC_NONE;
                saw_cr_next       = 1'b0;
                remain_next       = '0;
                line_started_next = 1'b0;
                reported_next     = 1'b0;
            end else begin
                unique case (phase_reg)
                    PH_HALT:
                    begin
                    end
                    PH_DATA:
                    begin
                        remain_next = remain_dec;
                        if (remain_dec == '0) begin
                            phase_next  = PH_SEP;
                            remain_next = SIZE_BITS'(SEP_LEN);
                        end
                    end
                    PH_SEP:
                    begin
                        remain_next = remain_dec;
                        if (remain_dec == '0) begin
                            phase_next        = PH_LEAD;
                            acc_next          = '0;
                            digits_next       = DC_NONE;
                            saw_cr_next       = 1'b0;
                            line_started_next = 1'b0;
                        end
                    end
                    default:
                    begin
                        line_started_next = 1'b1;
                        if (line_end) begin
                            saw_cr_next = 1'b0;
                            if (digits_reg != DC_SOME || acc_reg == '0) begin
                                phase_next    = PH_HALT;
                                reported_next = 1'b1;
                            end else begin
                                remain_next = acc_reg;
                                phase_next  = PH_DATA;
                            end
                        end else begin
                            saw_cr_next = (s_tdata == CHR_CR);
                            // A leading zero may open a 0x prefix.
                            if (phase_reg == PH_LEAD && s_tdata == CHR_ZERO) begin
                                digits_next = DC_SOME;
                                acc_next    = '0;
                                phase_next  = PH_ZERO;
                            end else if (phase_reg == PH_ZERO
                                         && (s_tdata == CHR_X_LC || s_tdata == CHR_X_UC)) begin
                                phase_next = PH_PREFIX;
                            end else if (is_digit && phase_reg != PH_TAIL) begin
                                phase_next = PH_DIGITS;
                                // Gather the digit unless the count would overflow.
                                if (digits_reg != DC_OVERFLOW) begin
                                    if (acc_reg[SIZE_BITS-1 -: HEX_DIGIT_BITS] != '0) begin
                                        digits_next = DC_OVERFLOW;
                                    end else begin
                                        acc_next    = {acc_reg[SIZE_BITS-HEX_DIGIT_BITS-1:0],
                                                       hex[3:0]};
                                        digits_next = DC_SOME;
                                    end
                                end
                            end else if (phase_reg == PH_LEAD) begin
                                if (!is_blank(s_tdata)) begin
                                    phase_next = PH_TAIL;
                                end
                            end else begin
                                phase_next = PH_TAIL;
                            end
                        end
                    end
                endcase
            end
        end
    end

    // Result of the current request.
    always_comb
    begin
        res_valid  = 1'b0;
        res_byte   = 8'd0;
        res_status = ST_PAYLOAD;
        if (s_tlast) begin
            res_valid = !reported_reg;
            if (phase_reg == PH_DATA || phase_reg == PH_SEP) begin
                res_status = ST_TRUNCATED;
            end else if (line_started_reg) begin
                res_status = ST_NO_CRLF;
            end else begin
                res_status = ST_DONE;
            end
        end else begin
            unique case (phase_reg) inside
                PH_HALT, PH_SEP:
                begin
                end
                PH_DATA:
                begin
                    res_valid = 1'b1;
                    res_byte  = s_tdata;
                end
                default:
                begin
                    // A finished size line reports only a bad or a zero count.
                    if (line_end) begin
                        res_valid  = (digits_reg != DC_SOME) || (acc_reg == '0);
                        res_status = (digits_reg != DC_SOME) ? ST_BAD_SIZE : ST_DONE;
                    end
                end
            endcase
        end
    end

    // Output register handshake.
    assign out_valid_next = accept ? res_valid : (out_valid_reg && !m_tready);

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg        <= PH_LEAD;
            acc_reg          <= '0;
            digits_reg       <= DC_NONE;
            saw_cr_reg       <= 1'b0;
            remain_reg       <= '0;
            line_started_reg <= 1'b0;
            reported_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            phase_reg        <= phase_next;
            acc_reg          <= acc_next;
            digits_reg       <= digits_next;
            saw_cr_reg       <= saw_cr_next;
            remain_reg       <= remain_next;
            line_started_reg <= line_started_next;
            reported_reg     <= reported_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        if (accept && res_valid) begin
            out_byte_reg   <= res_byte;
            out_status_reg <= res_status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_status_reg;

    // The status has been given exactly when the parser is halted.
    a_halt_matches_report: assert property (@(posedge clk) disable iff (!rst_n)
        reported_reg == (phase_reg == PH_HALT))
        else $error("halt phase and status flag disagree");

    // A chunk in progress always has bytes left.
    a_data_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> remain_reg != '0)
        else $error("data phase with zero bytes remaining");

    // The separator count stays within its length.
    a_sep_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_SEP |-> (remain_reg == SIZE_BITS'(1) || remain_reg == SIZE_BITS'(2)))
        else $error("separator count out of range");

    // End of body returns the parser to a fresh size line.
    a_eob_restart: assert property (@(posedge clk) disable iff (!rst_n)
        accept && s_tlast |=> phase_reg == PH_LEAD && !reported_reg && !line_started_reg)
        else $error("end of body did not restart the parser");

    // A held result is not overwritten while the receiver stalls.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_tready |-> !accept)
        else $error("request taken while a result is stalled");

endmodule
